[rtl/stc_pkg.sv]
// Package for the source character tokenizer: token kinds, scan modes,
// character classes and sizing constants. No dependencies.
package stc_pkg;

  // Default widths of the position and line counters
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned LINE_BITS_DEF     = 20;

  localparam int unsigned KIND_BITS  = 5;
  localparam int unsigned FIFO_DEPTH = 4;

  // Token kinds
  localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_LBRACKET  = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_RBRACKET  = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_COMMA     = 5'd6;
  localparam logic [KIND_BITS-1:0] KIND_DOT       = 5'd7;
  localparam logic [KIND_BITS-1:0] KIND_MINUS     = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_PLUS      = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_COLON     = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_SLASH     = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_STAR      = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_BANG      = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_NOT_EQUAL = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_EQUAL     = 5'd16;
  localparam logic [KIND_BITS-1:0] KIND_EQ_EQ     = 5'd17;
  localparam logic [KIND_BITS-1:0] KIND_GREATER   = 5'd18;
  localparam logic [KIND_BITS-1:0] KIND_GREATER_EQ = 5'd19;
  localparam logic [KIND_BITS-1:0] KIND_LESS      = 5'd20;
  localparam logic [KIND_BITS-1:0] KIND_LESS_EQ   = 5'd21;
  localparam logic [KIND_BITS-1:0] KIND_STRING    = 5'd22;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 5'd23;
  localparam logic [KIND_BITS-1:0] KIND_IDENT     = 5'd24;
  localparam logic [KIND_BITS-1:0] KIND_ERROR     = 5'd25;

  // Scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_BANG    = 4'd1,
    MODE_EQ      = 4'd2,
    MODE_LT      = 4'd3,
    MODE_GT      = 4'd4,
    MODE_SLASH   = 4'd5,
    MODE_COMMENT = 4'd6,
    MODE_SQ      = 4'd7,
    MODE_DQ      = 4'd8,
    MODE_NINT    = 4'd9,
    MODE_NDOT    = 4'd10,
    MODE_NFRAC   = 4'd11,
    MODE_IDENT   = 4'd12
  } mode_t;

  // Scanner push into the result queue: which of the two slots are used
  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  // Single-byte punctuation: valid flag and kind
  function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] c);
    logic [KIND_BITS:0] r;
    r = '0;
    case (c)
      "(":     r = {1'b1, KIND_LPAREN};
      ")":     r = {1'b1, KIND_RPAREN};
      "{":     r = {1'b1, KIND_LBRACE};
      "}":     r = {1'b1, KIND_RBRACE};
      "[":     r = {1'b1, KIND_LBRACKET};
      "]":     r = {1'b1, KIND_RBRACKET};
      ",":     r = {1'b1, KIND_COMMA};
      ".":     r = {1'b1, KIND_DOT};
      "-":     r = {1'b1, KIND_MINUS};
      "+":     r = {1'b1, KIND_PLUS};
      ";":     r = {1'b1, KIND_SEMICOLON};
      ":":     r = {1'b1, KIND_COLON};
      "*":     r = {1'b1, KIND_STAR};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Base kind of a pending comparison; the '=' form is one above it
  function automatic logic [KIND_BITS-1:0] op_kind(input mode_t m);
    logic [KIND_BITS-1:0] k;
    case (m)
      MODE_BANG: k = KIND_BANG;
      MODE_EQ:   k = KIND_EQUAL;
      MODE_LT:   k = KIND_LESS;
      default:   k = KIND_GREATER;
    endcase
    return k;
  endfunction

endpackage

[rtl/stc_scan.sv]
// Scanner core: mode, token start, byte offset and line registers, plus the
// one-pass logic that turns a byte into up to two packed results. Uses stc_pkg.
module stc_scan #(
  parameter int unsigned POSITION_BITS = stc_pkg::POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = stc_pkg::LINE_BITS_DEF,
  localparam int unsigned RES_W = stc_pkg::KIND_BITS + 2 * POSITION_BITS + LINE_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            character,
  input  logic                  end_of_source,
  output stc_pkg::push_t        push,
  output logic [RES_W-1:0]      res0,
  output logic [RES_W-1:0]      res1
);

  localparam int unsigned KB = stc_pkg::KIND_BITS;

  stc_pkg::mode_t           mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;

  // Classes of the incoming byte
  logic c_dig, c_let, c_ws, c_nl;
  logic [KB:0] c_punct;
  assign c_dig   = stc_pkg::is_numeral(character);
  assign c_let   = stc_pkg::is_letter(character);
  assign c_ws    = stc_pkg::is_space(character);
  assign c_nl    = (character == 8'h0A);
  assign c_punct = stc_pkg::punct_kind(character);

  // Fresh token start on this byte
  stc_pkg::mode_t    bt_mode;
  logic              bt_emit;
  logic [KB-1:0]     bt_kind;
  logic [POSITION_BITS-1:0] bt_len;
  always_comb begin
    bt_mode = stc_pkg::MODE_IDLE;
    bt_emit = 1'b0;
    bt_kind = stc_pkg::KIND_ERROR;
    bt_len  = '0;
    if (character == "!")        bt_mode = stc_pkg::MODE_BANG;
    else if (character == "=")   bt_mode = stc_pkg::MODE_EQ;
    else if (character == "<")   bt_mode = stc_pkg::MODE_LT;
    else if (character == ">")   bt_mode = stc_pkg::MODE_GT;
    else if (character == "/")   bt_mode = stc_pkg::MODE_SLASH;
    else if (character == "'")   bt_mode = stc_pkg::MODE_SQ;
    else if (character == "\"")  bt_mode = stc_pkg::MODE_DQ;
    else if (c_punct[KB]) begin
      bt_emit = 1'b1;
      bt_kind = c_punct[KB-1:0];
      bt_len  = POSITION_BITS'(1);
    end else if (c_dig)          bt_mode = stc_pkg::MODE_NINT;
    else if (c_let)              bt_mode = stc_pkg::MODE_IDENT;
    else if (!c_ws)              bt_emit = 1'b1;
  end

  // Continue or close the pending token
  logic [POSITION_BITS-1:0] tok_span;
  assign tok_span = pos_r - begin_r;

  logic                     restart, feed_nl, e1_v;
  stc_pkg::mode_t           feed_mode;
  logic [KB-1:0]            e1_kind;
  logic [POSITION_BITS-1:0] e1_len;
  always_comb begin
    restart   = 1'b0;
    feed_nl   = 1'b0;
    feed_mode = mode_r;
    e1_v      = 1'b0;
    e1_kind   = stc_pkg::KIND_ERROR;
    e1_len    = '0;
    unique case (mode_r)
      stc_pkg::MODE_BANG, stc_pkg::MODE_EQ, stc_pkg::MODE_LT, stc_pkg::MODE_GT: begin
        e1_v = 1'b1;
        if (character == "=") begin
          e1_kind   = stc_pkg::op_kind(mode_r) + KB'(1);
          e1_len    = tok_span + POSITION_BITS'(1);
          feed_mode = stc_pkg::MODE_IDLE;
        end else begin
          e1_kind = stc_pkg::op_kind(mode_r);
          e1_len  = tok_span;
          restart = 1'b1;
        end
      end
      stc_pkg::MODE_SLASH: begin
        if (character == "/") begin
          feed_mode = stc_pkg::MODE_COMMENT;
        end else begin
          e1_v    = 1'b1;
          e1_kind = stc_pkg::KIND_SLASH;
          e1_len  = tok_span;
          restart = 1'b1;
        end
      end
      stc_pkg::MODE_COMMENT: begin
        if (c_nl) begin
          feed_nl   = 1'b1;
          feed_mode = stc_pkg::MODE_IDLE;
        end
      end
      stc_pkg::MODE_SQ, stc_pkg::MODE_DQ: begin
        if (character == ((mode_r == stc_pkg::MODE_SQ) ? 8'("'") : 8'("\""))) begin
          e1_v      = 1'b1;
          e1_kind   = stc_pkg::KIND_STRING;
          e1_len    = tok_span + POSITION_BITS'(1);
          feed_mode = stc_pkg::MODE_IDLE;
        end else if (c_nl) begin
          feed_nl = 1'b1;
        end
      end
      stc_pkg::MODE_NINT, stc_pkg::MODE_NFRAC: begin
        if (c_dig) begin
          feed_mode = mode_r;
        end else if ((character == ".") && (mode_r == stc_pkg::MODE_NINT)) begin
          feed_mode = stc_pkg::MODE_NDOT;
        end else begin
          e1_v    = 1'b1;
          restart = 1'b1;
          if (c_ws) begin
            e1_kind = stc_pkg::KIND_NUMBER;
            e1_len  = tok_span;
          end
        end
      end
      stc_pkg::MODE_NDOT: begin
        if (c_dig) begin
          feed_mode = stc_pkg::MODE_NFRAC;
        end else begin
          e1_v    = 1'b1;
          restart = 1'b1;
        end
      end
      stc_pkg::MODE_IDENT: begin
        if (!(c_let || c_dig)) begin
          e1_v    = 1'b1;
          e1_kind = stc_pkg::KIND_IDENT;
          e1_len  = tok_span;
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase
  end

  // State after this byte, before any end-of-source flush
  stc_pkg::mode_t           m2;
  logic [POSITION_BITS-1:0] begin2;
  logic [LINE_BITS-1:0]     line_mid;
  logic                     line_inc, bt_v;
  assign m2       = restart ? bt_mode : feed_mode;
  assign begin2   = restart ? pos_r : begin_r;
  assign line_inc = feed_nl || (restart && c_nl);
  assign line_mid = (line_inc && (line_r != '1)) ? line_r + LINE_BITS'(1) : line_r;
  assign bt_v     = restart && bt_emit;

  // Closing of whatever is still open at end of source
  logic                     fl_v;
  logic [KB-1:0]            fl_kind;
  logic [POSITION_BITS-1:0] fl_len, fl_span;
  assign fl_span = pos_r - begin2 + POSITION_BITS'(1);
  always_comb begin
    fl_v    = 1'b0;
    fl_kind = stc_pkg::KIND_ERROR;
    fl_len  = '0;
    unique case (m2)
      stc_pkg::MODE_BANG, stc_pkg::MODE_EQ, stc_pkg::MODE_LT, stc_pkg::MODE_GT: begin
        fl_v = 1'b1; fl_kind = stc_pkg::op_kind(m2); fl_len = fl_span;
      end
      stc_pkg::MODE_SLASH: begin
        fl_v = 1'b1; fl_kind = stc_pkg::KIND_SLASH; fl_len = fl_span;
      end
      stc_pkg::MODE_SQ, stc_pkg::MODE_DQ, stc_pkg::MODE_NDOT: begin
        fl_v = 1'b1;
      end
      stc_pkg::MODE_NINT, stc_pkg::MODE_NFRAC: begin
        fl_v = 1'b1; fl_kind = stc_pkg::KIND_NUMBER; fl_len = fl_span;
      end
      stc_pkg::MODE_IDENT: begin
        fl_v = 1'b1; fl_kind = stc_pkg::KIND_IDENT; fl_len = fl_span;
      end
      default: fl_v = 1'b0;
    endcase
    fl_v = fl_v && end_of_source;
  end

  // Pack candidates {kind, start, length, line, last}; compact to two slots
  localparam int unsigned PW = RES_W - 1;
  logic [PW-1:0] e1_p, bt_p, fl_p, r0_p, r1_p;
  assign e1_p = {e1_kind, begin_r, e1_len, line_r};
  assign bt_p = {bt_kind, pos_r, bt_len, line_r};
  assign fl_p = {fl_kind, begin2, fl_len, line_mid};

  always_comb begin
    push = '0;
    r0_p = fl_p;
    r1_p = fl_p;
    if (e1_v) begin
      r0_p    = e1_p;
      push.v0 = 1'b1;
      r1_p    = bt_v ? bt_p : fl_p;
      push.v1 = bt_v || fl_v;
    end else if (bt_v) begin
      r0_p    = bt_p;
      push.v0 = 1'b1;
      push.v1 = fl_v;
    end else begin
      push.v0 = fl_v;
    end
    push.v0 = push.v0 && take;
    push.v1 = push.v1 && take;
  end
  assign res0 = {r0_p, !push.v1};
  assign res1 = {r1_p, 1'b1};

  // State update; end of source returns everything to reset values
  always_comb begin
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    if (take) begin
      if (end_of_source) begin
        mode_nxt  = stc_pkg::MODE_IDLE;
        begin_nxt = '0;
        pos_nxt   = '0;
        line_nxt  = LINE_BITS'(1);
      end else begin
        mode_nxt  = m2;
        begin_nxt = begin2;
        line_nxt  = line_mid;
        pos_nxt   = (pos_r != '1) ? pos_r + POSITION_BITS'(1) : pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stc_pkg::MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
      line_r  <= LINE_BITS'(1);
    end else begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
    end
  end

  // Line count starts at one and never wraps to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0) else $error("line count reached zero");

  // End of source brings the scanner back to its reset state
  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    take && end_of_source |=> (pos_r == '0) && (mode_r == stc_pkg::MODE_IDLE)
      && (line_r == LINE_BITS'(1))) else $error("scanner not reset after end of source");

  // Second slot is only used together with the first
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0) else $error("second result without first");

  // Token start never lies ahead of the current offset
  a_begin_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    begin_r <= pos_r) else $error("token start beyond byte offset");

endmodule

[rtl/stc_result_fifo.sv]
// Small result queue between the scanner and the output channel; takes up to
// two results per cycle and hands out one while out_ready is high. Uses stc_pkg.
module stc_result_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stc_pkg::push_t   push,
  input  logic [WIDTH-1:0] wr0,
  input  logic [WIDTH-1:0] wr1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int unsigned DEPTH = stc_pkg::FIFO_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [AW:0]      count_r, count_nxt;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (count_r <= (AW + 1)'(DEPTH - 2));
  assign wr_ptr1   = wr_ptr_r + AW'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.v0) + AW'(push.v1);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + (AW + 1)'(push.v0) + (AW + 1)'(push.v1) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_ptr_r] <= wr0;
    if (push.v1) mem_r[wr_ptr1]  <= wr1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW + 1)'(DEPTH)) else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> room) else $error("double push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push.v0 && !push.v1 |=> count_r == $past(count_r) - (AW + 1)'(1))
    else $error("queue count did not drop on pop");

endmodule

[rtl/source_character_tokenizer.sv]
// A byte is registered in the input item register when accepted, scanned
// from there straight into the result queue once the queue has room, and
// its first token is on out_* once the queue holds it. Throughput: one byte
// per cycle while each byte gives at most one token and the queue drains;
// a byte giving two tokens pushes both into the four-entry result queue,
// which hands them out one at a time. Reset: synchronous active-low rst_n
// clears mode, offset and queue, sets the line count to 1; no clearing pass.
module source_character_tokenizer #(
  parameter int unsigned POSITION_BITS = stc_pkg::POSITION_BITS_DEF,
  parameter int unsigned LINE_BITS     = stc_pkg::LINE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_character,
  input  logic                         in_end_of_source,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stc_pkg::KIND_BITS-1:0] out_token_kind,
  output logic [POSITION_BITS-1:0]     out_token_start,
  output logic [POSITION_BITS-1:0]     out_token_length,
  output logic [LINE_BITS-1:0]         out_line_number,
  output logic                         out_last_of_run
);

  localparam int unsigned RES_W = stc_pkg::KIND_BITS + 2 * POSITION_BITS + LINE_BITS + 1;

  // Input item register
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_char_r;
  logic       hold_eos_r;
  logic       take, room;

  assign take     = hold_v_r && room;
  assign in_ready = !hold_v_r || take;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (in_valid && in_ready) hold_v_nxt = 1'b1;
    else if (take)            hold_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_v_r <= 1'b0;
    else        hold_v_r <= hold_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char_r <= in_character;
      hold_eos_r  <= in_end_of_source;
    end
  end

  // Scanner
  stc_pkg::push_t   push;
  logic [RES_W-1:0] res0, res1, head;

  stc_scan #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .character     (hold_char_r),
    .end_of_source (hold_eos_r),
    .push          (push),
    .res0          (res0),
    .res1          (res1)
  );

  // Result queue and output unpacking
  stc_result_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr0       (res0),
    .wr1       (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign {out_token_kind, out_token_start, out_token_length, out_line_number,
          out_last_of_run} = head;

endmodule
